[src/lpht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg - shared types and constants for the linear-probe hash table
// Command, status and sequencer state codes, plus the per-slot state word.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int FILL_LIMIT_W = 7;
  localparam logic [FILL_LIMIT_W-1:0] FILL_LIMIT_RESET = 7'd48;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_DEL   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PROBE,
    S_CLEAR,
    S_RESP
  } seq_state_t;

  // Slot occupancy: empty when both bits are low
  typedef struct packed {
    logic used;
    logic tomb;
  } slot_state_t;

endpackage

[src/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table - open-addressing key/value table
// Linear probing with tombstones; get, set, delete and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on the s_axis group (cmd in tuser; key, hash and value in
//   tdata) and exactly one result leaves on the m_axis group (status and hit in
//   tuser, read value in tdata). cfg_we writes the fill limit; write it only
//   while no request is in flight.
//   The probe reads one slot per cycle from the slot memory. A get, set or
//   delete walks a probe run of 1 to CAPACITY slots, then resolves the
//   request and loads its result into the output register; the next request
//   is taken once the sequencer is back in idle. A clear sweeps the memory
//   one slot per cycle and then loads its result.
//   After rst the same sweep runs over every slot with s_axis_tready low.
//   The result sits in an output register; if the receiver stalls, a finished
//   request waits for that register before its write-back, and s_axis_tready
//   stays low until then. CAPACITY must be a power of two.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [127:0]                      s_axis_tdata,  // key_id, key_hash, write_value
  input  logic [1:0]                        s_axis_tuser,  // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [63:0]                       m_axis_tdata,  // read_value
  output logic [2:0]                        m_axis_tuser,  // status, hit
  input  logic                              cfg_we,
  input  logic [lpht_pkg::FILL_LIMIT_W-1:0] cfg_wdata
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  logic [FILL_LIMIT_W-1:0] fill_limit;
  logic [31:0]             key_id;
  logic [31:0]             key_hash;
  logic [63:0]             write_value;
  logic [KEY_BITS-1:0]     key_in;
  logic [VALUE_BITS-1:0]   out_value;
  status_t                 out_status;
  logic                    out_hit;

  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  slot_state_t             rd_state, wr_state;
  logic [KEY_BITS-1:0]     rd_key, wr_key;
  logic [VALUE_BITS-1:0]   rd_data, wr_data;

  assign key_id      = s_axis_tdata[31:0];
  assign key_hash    = s_axis_tdata[63:32];
  assign write_value = s_axis_tdata[127:64];

  generate
    if (KEY_BITS <= 32) begin : g_key_narrow
      assign key_in = key_id[KEY_BITS-1:0];
    end else begin : g_key_wide
      assign key_in = {{(KEY_BITS-32){1'b0}}, key_id};
    end
    if (VALUE_BITS < 64) begin : g_val_narrow
      assign m_axis_tdata = {{(64-VALUE_BITS){1'b0}}, out_value};
    end else begin : g_val_full
      assign m_axis_tdata = out_value;
    end
  endgenerate

  assign m_axis_tuser = {out_hit, out_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_limit <= FILL_LIMIT_RESET;
    end else if (cfg_we) begin
      fill_limit <= cfg_wdata;
    end
  end

  lpht_seq #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (cmd_t'(s_axis_tuser)),
    .in_key     (key_in),
    .in_slot    (key_hash[IDX_W-1:0]),
    .in_value   (write_value[VALUE_BITS-1:0]),
    .fill_limit (fill_limit),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_hit    (out_hit),
    .out_value  (out_value),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_state   (rd_state),
    .rd_key     (rd_key),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_state   (wr_state),
    .wr_key     (wr_key),
    .wr_data    (wr_data)
  );

  lpht_slot_mem #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_slot_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_state (rd_state),
    .rd_key   (rd_key),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_state (wr_state),
    .wr_key   (wr_key),
    .wr_data  (wr_data)
  );

endmodule

[src/lpht_slot_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_slot_mem - slot storage
// One write port and one registered read port over slot state, key and data.
// ----------------------------------------------------------------------------
module lpht_slot_mem #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output lpht_pkg::slot_state_t       rd_state,
  output logic [KEY_BITS-1:0]         rd_key,
  output logic [VALUE_BITS-1:0]       rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  lpht_pkg::slot_state_t       wr_state,
  input  logic [KEY_BITS-1:0]         wr_key,
  input  logic [VALUE_BITS-1:0]       wr_data
);
  import lpht_pkg::*;

  slot_state_t             state_mem [CAPACITY];
  logic [KEY_BITS-1:0]     key_mem   [CAPACITY];
  logic [VALUE_BITS-1:0]   data_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[wr_addr] <= wr_state;
      key_mem[wr_addr]   <= wr_key;
      data_mem[wr_addr]  <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_state <= state_mem[rd_addr];
      rd_key   <= key_mem[rd_addr];
      rd_data  <= data_mem[rd_addr];
    end
  end

endmodule

[src/lpht_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_seq - probe sequencer
// Walks the slot memory one slot per cycle with a single key comparator,
// resolves the request, writes back and loads the result register.
// ----------------------------------------------------------------------------
module lpht_seq #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lpht_pkg::cmd_t                      in_cmd,
  input  logic [KEY_BITS-1:0]                 in_key,
  input  logic [$clog2(CAPACITY)-1:0]         in_slot,
  input  logic [VALUE_BITS-1:0]               in_value,
  input  logic [lpht_pkg::FILL_LIMIT_W-1:0]   fill_limit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lpht_pkg::status_t                   out_status,
  output logic                                out_hit,
  output logic [VALUE_BITS-1:0]               out_value,
  output logic                                rd_en,
  output logic [$clog2(CAPACITY)-1:0]         rd_addr,
  input  lpht_pkg::slot_state_t               rd_state,
  input  logic [KEY_BITS-1:0]                 rd_key,
  input  logic [VALUE_BITS-1:0]               rd_data,
  output logic                                wr_en,
  output logic [$clog2(CAPACITY)-1:0]         wr_addr,
  output lpht_pkg::slot_state_t               wr_state,
  output logic [KEY_BITS-1:0]                 wr_key,
  output logic [VALUE_BITS-1:0]               wr_data
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int FC_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((FC_W > FILL_LIMIT_W) ? FC_W : FILL_LIMIT_W) + 1;

  seq_state_t state, state_next;

  // request
  cmd_t                  req_cmd;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  // probe walk
  logic [IDX_W-1:0]      issue_idx;
  logic [IDX_W-1:0]      eval_idx;
  logic [IDX_W-1:0]      probe_n;
  logic                  rd_pending;
  logic                  tomb_seen;
  logic [IDX_W-1:0]      tomb_idx;
  logic                  found;
  logic                  have_slot;
  logic                  is_empty;
  logic [IDX_W-1:0]      slot_idx;
  logic [VALUE_BITS-1:0] found_data;

  logic [FC_W-1:0]       fill_count;
  logic [IDX_W-1:0]      clr_idx;

  logic slot_match, slot_tomb, slot_empty, probe_last, probe_stop;
  logic out_free, load_out, accept, fill_over, bump_fill;
  status_t               res_status;
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_value;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign slot_match = rd_pending && rd_state.used && (rd_key == req_key);
  assign slot_tomb  = rd_pending && !rd_state.used && rd_state.tomb;
  assign slot_empty = rd_pending && !rd_state.used && !rd_state.tomb;
  assign probe_last = rd_pending && (probe_n == '1);
  assign probe_stop = slot_match || slot_empty || probe_last;
  assign fill_over  = (CMP_W'(fill_count) + CMP_W'(1)) > CMP_W'(fill_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = issue_idx;
    wr_en      = 1'b0;
    wr_addr    = slot_idx;
    wr_state   = '0;
    wr_key     = req_key;
    wr_data    = req_value;
    load_out   = 1'b0;
    bump_fill  = 1'b0;
    res_status = ST_OK;
    res_hit    = 1'b0;
    res_value  = '0;

    // resolve the request from the probe outcome
    case (req_cmd)
      CMD_GET: begin
        if (found) begin
          res_hit   = 1'b1;
          res_value = found_data;
        end else begin
          res_status = ST_MISS;
        end
      end
      CMD_DEL: begin
        if (found) begin
          res_hit       = 1'b1;
          wr_state.tomb = 1'b1;
        end else begin
          res_status = ST_MISS;
        end
      end
      CMD_SET: begin
        wr_state.used = 1'b1;
        if (!found) begin
          if (!have_slot || (is_empty && fill_over)) begin
            res_status = ST_FULL;
          end else begin
            res_hit   = 1'b1;
            bump_fill = is_empty;
          end
        end
      end
      default: ;
    endcase

    case (state)
      S_INIT, S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr_idx;
        wr_state = '0;
        if (clr_idx == '1) begin
          state_next = (state == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (in_cmd == CMD_CLEAR) ? S_CLEAR : S_PROBE;
        end
      end
      S_PROBE: begin
        rd_en = 1'b1;
        if (probe_stop) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          wr_en      = (req_cmd == CMD_DEL && found) ||
                       (req_cmd == CMD_SET && res_status == ST_OK);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      fill_count <= '0;
      clr_idx    <= '0;
    end else begin
      if (state == S_INIT || state == S_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (req_cmd == CMD_CLEAR) begin
          fill_count <= '0;
        end else if (bump_fill) begin
          fill_count <= fill_count + FC_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and probe payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd    <= in_cmd;
      req_key    <= in_key;
      req_value  <= in_value;
      issue_idx  <= in_slot;
      probe_n    <= '0;
      rd_pending <= 1'b0;
      tomb_seen  <= 1'b0;
      found      <= 1'b0;
      have_slot  <= 1'b0;
      is_empty   <= 1'b0;
    end else if (state == S_PROBE) begin
      issue_idx  <= issue_idx + IDX_W'(1);
      eval_idx   <= issue_idx;
      rd_pending <= 1'b1;
      if (rd_pending) begin
        probe_n <= probe_n + IDX_W'(1);
        if (slot_tomb && !tomb_seen) begin
          tomb_seen <= 1'b1;
          tomb_idx  <= eval_idx;
        end
        if (slot_match) begin
          found      <= 1'b1;
          slot_idx   <= eval_idx;
          found_data <= rd_data;
        end else if (slot_empty) begin
          have_slot <= 1'b1;
          slot_idx  <= tomb_seen ? tomb_idx : eval_idx;
          is_empty  <= !tomb_seen;
        end else if (probe_last) begin
          // whole table walked: fall back to the first tombstone, if any
          have_slot <= tomb_seen || slot_tomb;
          slot_idx  <= tomb_seen ? tomb_idx : eval_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_hit    <= res_hit;
      out_value  <= res_value;
    end
  end

  a_wr_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_INIT || state == S_CLEAR || state == S_RESP))
    else $error("slot write outside clear or write-back");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (CMP_W'(fill_count) <= CMP_W'(CAPACITY)))
    else $error("fill count above capacity");

  a_fill_bump: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_free && req_cmd == CMD_SET && res_hit && is_empty) |=>
      (fill_count == $past(fill_count) + FC_W'(1)))
    else $error("empty slot claimed without fill count rise");

  a_probe_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && in_cmd != CMD_CLEAR) |=> (state == S_PROBE))
    else $error("request accepted without probe");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE || state == S_RESP) |-> !in_ready)
    else $error("request taken while busy");

endmodule
